// ===== src/tob_pkg.sv =====
// ----------------------------------------------------------------------------
// tob_pkg: shared types, constants and font for the 5x7 text overlay blender
// Glyph lookup, command codes, controller states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tob_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_DRAW  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_ORG_X  = 3'd2,
		REG_ORG_Y  = 3'd3,
		REG_COLOR  = 3'd4,
		REG_ALPHA  = 3'd5,
		REG_SCALE  = 3'd6,
		REG_SPARE  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_READ,
		ST_BLEND,
		ST_WRITE,
		ST_DONE,
		ST_OUT
	} state_t;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_MAX     = 8'd255;

	typedef struct packed {
		logic load;       // latch item
		logic cursor_upd; // apply end-of-item cursor update
		logic dot_next;   // advance dot / sub-pixel walk
		logic rd_en;      // issue store read at walk address
		logic blend;      // register blended pixel
		logic wr_en;      // write blended pixel
		logic out_load;   // capture result
	} dp_cmd_t;

	typedef struct packed {
		logic is_draw;
		logic is_newline;
		logic walk_done;  // last position of the glyph walk
		logic hit;        // current position is lit and in bounds
	} dp_sts_t;

	function automatic logic [34:0] glyph(input logic [7:0] code_in);
		logic [7:0] c;
		logic [39:0] g;
		c = code_in;
		if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
		unique case (c)
			8'h30: g = 40'h3e_51_49_45_3e; 8'h31: g = 40'h00_42_7f_40_00;
			8'h32: g = 40'h42_61_51_49_46; 8'h33: g = 40'h21_41_45_4b_31;
			8'h34: g = 40'h18_14_12_7f_10; 8'h35: g = 40'h27_45_45_45_39;
			8'h36: g = 40'h3c_4a_49_49_30; 8'h37: g = 40'h01_71_09_05_03;
			8'h38: g = 40'h36_49_49_49_36; 8'h39: g = 40'h06_49_49_29_1e;
			8'h41: g = 40'h7e_11_11_11_7e; 8'h42: g = 40'h7f_49_49_49_36;
			8'h43: g = 40'h3e_41_41_41_22; 8'h44: g = 40'h7f_41_41_22_1c;
			8'h45: g = 40'h7f_49_49_49_41; 8'h46: g = 40'h7f_09_09_09_01;
			8'h47: g = 40'h3e_41_49_49_7a; 8'h48: g = 40'h7f_08_08_08_7f;
			8'h49: g = 40'h00_41_7f_41_00; 8'h4a: g = 40'h20_40_41_3f_01;
			8'h4b: g = 40'h7f_08_14_22_41; 8'h4c: g = 40'h7f_40_40_40_40;
			8'h4d: g = 40'h7f_02_0c_02_7f; 8'h4e: g = 40'h7f_04_08_10_7f;
			8'h4f: g = 40'h3e_41_41_41_3e; 8'h50: g = 40'h7f_09_09_09_06;
			8'h51: g = 40'h3e_41_51_21_5e; 8'h52: g = 40'h7f_09_19_29_46;
			8'h53: g = 40'h46_49_49_49_31; 8'h54: g = 40'h01_01_7f_01_01;
			8'h55: g = 40'h3f_40_40_40_3f; 8'h56: g = 40'h1f_20_40_20_1f;
			8'h57: g = 40'h7f_20_18_20_7f; 8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h07_08_70_08_07; 8'h5a: g = 40'h61_51_49_45_43;
			8'h2e: g = 40'h00_60_60_00_00; 8'h2c: g = 40'h00_40_20_00_00;
			8'h3a: g = 40'h00_36_36_00_00; 8'h3b: g = 40'h00_36_36_20_00;
			8'h2d: g = 40'h00_08_08_08_00; 8'h5f: g = 40'h40_40_40_40_40;
			8'h2b: g = 40'h08_08_3e_08_08; 8'h3d: g = 40'h00_14_14_14_00;
			8'h2a: g = 40'h14_08_3e_08_14; 8'h21: g = 40'h00_00_5f_00_00;
			8'h3f: g = 40'h02_01_51_09_06; 8'h27: g = 40'h00_00_06_00_00;
			8'h22: g = 40'h00_06_00_06_00; 8'h2f: g = 40'h60_10_08_04_03;
			8'h5c: g = 40'h03_04_08_10_60; 8'h28: g = 40'h00_1c_22_41_00;
			8'h29: g = 40'h00_41_22_1c_00; 8'h5b: g = 40'h00_7f_41_41_00;
			8'h5d: g = 40'h00_41_41_7f_00; 8'h7b: g = 40'h00_08_36_41_00;
			8'h7d: g = 40'h00_41_36_08_00; 8'h3c: g = 40'h08_14_22_41_00;
			8'h3e: g = 40'h41_22_14_08_00; 8'h7c: g = 40'h00_00_7f_00_00;
			8'h23: g = 40'h14_7f_14_7f_14; 8'h25: g = 40'h61_64_08_13_23;
			default: g = 40'h0;
		endcase
		// column c occupies bits [7c+6:7c]
		glyph = {g[6:0], g[14:8], g[22:16], g[30:24], g[38:32]};
	endfunction

endpackage
`default_nettype wire

// ===== src/tob_if.sv =====
// ----------------------------------------------------------------------------
// tob_in_if / tob_out_if: valid/ready channels of the overlay blender
// Command channel and result channel with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface tob_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        first_char;
	logic [7:0]  char_code;
	logic [8:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [31:0] pixel_value;
	modport source (output valid, cmd, first_char, char_code, pixel_x, pixel_y,
		pixel_value, input ready);
	modport sink (input valid, cmd, first_char, char_code, pixel_x, pixel_y,
		pixel_value, output ready);
endinterface

interface tob_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        read_data;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic [11:0]        pixels_blended;
	modport source (output valid, read_data, cursor_x, cursor_y, pixels_blended,
		input ready);
	modport sink (input valid, read_data, cursor_x, cursor_y, pixels_blended,
		output ready);
endinterface
`default_nettype wire

// ===== src/tob_ctrl.sv =====
// ----------------------------------------------------------------------------
// tob_ctrl: sequencer of the overlay blender
// Walks item handling: pixel access, glyph walk with read-blend-write, result.
// ----------------------------------------------------------------------------
`default_nettype none
module tob_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire tob_pkg::dp_sts_t sts,
	output tob_pkg::dp_cmd_t      cmd
);
	import tob_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DOT;
				end
			end
			ST_DOT: begin
				// pixel commands also pass here; their store access is done at load
				if (!sts.is_draw || sts.is_newline) state_d = ST_DONE;
				else if (sts.hit) begin
					cmd.rd_en = 1'b1;
					state_d = ST_READ;
				end else if (sts.walk_done) state_d = ST_DONE;
				else cmd.dot_next = 1'b1;
			end
			ST_READ: state_d = ST_BLEND;
			ST_BLEND: begin
				cmd.blend = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				if (sts.walk_done) state_d = ST_DONE;
				else begin
					cmd.dot_next = 1'b1;
					state_d = ST_DOT;
				end
			end
			ST_DONE: begin
				cmd.cursor_upd = 1'b1;
				cmd.out_load = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/tob_dp.sv =====
// ----------------------------------------------------------------------------
// tob_dp: datapath of the overlay blender
// Frame store, glyph walk counters, address unit, blender, cursor and result.
// ----------------------------------------------------------------------------
`default_nettype none
module tob_dp #(
	parameter int FRAME_PIXELS = 131072,
	parameter int MAX_SCALE    = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tob_pkg::dp_cmd_t   cmd,
	output tob_pkg::dp_sts_t        sts,
	input  wire logic [1:0]         in_cmd,
	input  wire logic               in_first,
	input  wire logic [7:0]         in_code,
	input  wire logic [8:0]         in_x,
	input  wire logic [7:0]         in_y,
	input  wire logic [31:0]        in_value,
	input  wire logic [9:0]         frame_width,
	input  wire logic [8:0]         frame_height,
	input  wire logic signed [10:0] origin_x,
	input  wire logic signed [10:0] origin_y,
	input  wire logic [23:0]        text_color,
	input  wire logic [7:0]         text_alpha,
	input  wire logic [3:0]         text_scale,
	output logic [31:0]             read_data,
	output logic signed [15:0]      cursor_x,
	output logic signed [15:0]      cursor_y,
	output logic [11:0]             pixels_blended
);
	import tob_pkg::*;

	localparam int AW = $clog2(FRAME_PIXELS);
	localparam int SW = $clog2(MAX_SCALE + 1) + 1;

	logic [31:0] mem [FRAME_PIXELS];

	logic               draw_q, nl_q;
	logic [34:0]        glyph_q;
	logic [2:0]         col_q, row_q;
	logic [SW-1:0]      ox_q, oy_q, scale_q;
	logic signed [15:0] cur_x_q, cur_y_q;
	logic [AW-1:0]      addr_q;
	logic [31:0]        rdat_q, blend_q, pix_rd_q;
	logic [11:0]        cnt_q;
	logic               pix_ok_q;

	logic [SW-1:0]      eff_scale;
	logic signed [17:0] px, py;
	logic               lit, in_frame, last_ox, last_oy, last_dot;
	logic [28:0]        waddr_full, paddr_full;
	logic               paddr_ok;

	always_comb begin
		if (text_scale == 4'd0) eff_scale = SW'(1);
		else if ({{(SW > 4 ? SW - 4 : 0){1'b0}}, text_scale} > SW'(MAX_SCALE))
			eff_scale = SW'(MAX_SCALE);
		else eff_scale = SW'(text_scale);
	end

	// position of the current sub-pixel
	always_comb begin
		px = 18'(cur_x_q) + 18'(col_q) * 18'(scale_q) + 18'(ox_q);
		py = 18'(cur_y_q) + 18'(row_q) * 18'(scale_q) + 18'(oy_q);
		lit = glyph_q[7 * col_q + 32'(row_q)];
		in_frame = !px[17] && !py[17] && (px < $signed({8'd0, frame_width}))
			&& (py < $signed({9'd0, frame_height}));
		waddr_full = 29'(py[9:0]) * 29'(frame_width) + 29'(px[9:0]);
		last_ox = (ox_q == scale_q - SW'(1));
		last_oy = (oy_q == scale_q - SW'(1));
		last_dot = (col_q == 3'd4) && (row_q == 3'd6);
		paddr_full = 29'(in_y) * 29'(frame_width) + 29'(in_x);
		paddr_ok = ({1'b0, in_x} < frame_width) && ({1'b0, in_y} < frame_height)
			&& (paddr_full < 29'(FRAME_PIXELS));
	end

	always_comb begin
		sts.is_draw    = draw_q;
		sts.is_newline = nl_q;
		sts.hit        = lit && in_frame && (waddr_full < 29'(FRAME_PIXELS));
		sts.walk_done  = (!lit || (last_ox && last_oy)) && last_dot;
	end

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) sat16 = 16'sh7fff;
		else if (v < -18'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		logic [16:0] t;
		logic [16:0] q;
		t = 17'(s) * 17'(a) + 17'(d) * 17'(8'd255 - a);
		// t/255 for t < 65280: (t + 1 + (t >> 8)) >> 8
		q = t + 17'd1 + (t >> 8);
		mix = q[15:8];
	endfunction

	logic signed [15:0] start_x, start_y;
	always_comb begin
		start_x = in_first ? 16'(origin_x) : cur_x_q;
		start_y = in_first ? 16'(origin_y) : cur_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (cmd.load && in_cmd == CMD_DRAW) begin
			cur_x_q <= start_x;
			cur_y_q <= start_y;
		end else if (cmd.cursor_upd && draw_q) begin
			if (nl_q) begin
				cur_x_q <= 16'(origin_x);
				cur_y_q <= sat16(18'(cur_y_q) + 18'(scale_q) * 18'sd10);
			end else cur_x_q <= sat16(18'(cur_x_q) + 18'(scale_q) * 18'sd6);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			draw_q   <= (in_cmd == CMD_DRAW);
			nl_q     <= (in_code == CHAR_NEWLINE);
			glyph_q  <= glyph(in_code);
			scale_q  <= eff_scale;
			col_q    <= '0;
			row_q    <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			cnt_q    <= '0;
			pix_ok_q <= paddr_ok && (in_cmd == CMD_READ);
		end else if (cmd.dot_next) begin
			if (lit && !(last_ox && last_oy)) begin
				if (last_ox) begin
					ox_q <= '0;
					oy_q <= oy_q + SW'(1);
				end else ox_q <= ox_q + SW'(1);
			end else begin
				ox_q <= '0;
				oy_q <= '0;
				if (row_q == 3'd6) begin
					row_q <= '0;
					col_q <= col_q + 3'd1;
				end else row_q <= row_q + 3'd1;
			end
		end
		if (cmd.rd_en) addr_q <= waddr_full[AW-1:0];
		if (cmd.wr_en && cnt_q != 12'hfff) cnt_q <= cnt_q + 12'd1;
		if (cmd.blend)
			blend_q <= {8'hff, mix(text_color[23:16], rdat_q[23:16], text_alpha),
				mix(text_color[15:8], rdat_q[15:8], text_alpha),
				mix(text_color[7:0], rdat_q[7:0], text_alpha)};
		if (cmd.out_load) begin
			read_data      <= pix_ok_q ? pix_rd_q : 32'd0;
			pixels_blended <= cnt_q;
		end
	end

	always_comb begin
		cursor_x = cur_x_q;
		cursor_y = cur_y_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && paddr_ok && in_cmd == CMD_WRITE) mem[paddr_full[AW-1:0]] <= in_value;
		else if (cmd.wr_en) mem[addr_q] <= blend_q;
		if (cmd.load) pix_rd_q <= mem[paddr_full[AW-1:0]];
		else if (cmd.rd_en) rdat_q <= mem[waddr_full[AW-1:0]];
	end
endmodule
`default_nettype wire

// ===== src/text_overlay_5x7_blender_core.sv =====
// ----------------------------------------------------------------------------
// text_overlay_5x7_blender_core: 5x7 font text overlay with alpha blending
// Frame store with pixel load/readback and character drawing over it.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in      | in  | cmd, first_char, char_code, pixel_x, pixel_y, pixel_value
//  out     | out | read_data, cursor_x, cursor_y, pixels_blended
//  apb     | in  | registers 0..6 at 4*i
// Pixel and newline items pass through the IDLE, DOT, DONE and OUT states. A glyph
// visits each unlit dot and each sub-pixel of a lit dot one a cycle, and each
// in-frame pixel adds a store read, a blend and a write (READ, BLEND, WRITE).
// Reset clears cursor and registers; the frame store is not cleared. The
// result holds until taken.
`default_nettype none
module text_overlay_5x7_blender_core #(
	parameter int FRAME_PIXELS = 131072,
	parameter int MAX_SCALE    = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tob_in_if.sink           in,
	tob_out_if.source        out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import tob_pkg::*;

	logic [9:0]         width_q;
	logic [8:0]         height_q;
	logic signed [10:0] org_x_q, org_y_q;
	logic [23:0]        color_q;
	logic [7:0]         alpha_q;
	logic [3:0]         scale_q;
	reg_idx_t           ridx;
	dp_cmd_t            dcmd;
	dp_sts_t            dsts;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd320;
			height_q <= 9'd224;
			org_x_q  <= '0;
			org_y_q  <= '0;
			color_q  <= 24'hffffff;
			alpha_q  <= 8'hff;
			scale_q  <= 4'd1;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_WIDTH:  width_q  <= pwdata[9:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				REG_ORG_X:  org_x_q  <= pwdata[10:0];
				REG_ORG_Y:  org_y_q  <= pwdata[10:0];
				REG_COLOR:  color_q  <= pwdata[23:0];
				REG_ALPHA:  alpha_q  <= pwdata[7:0];
				REG_SCALE:  scale_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_ORG_X:  prdata = 32'(unsigned'(org_x_q));
			REG_ORG_Y:  prdata = 32'(unsigned'(org_y_q));
			REG_COLOR:  prdata = 32'(color_q);
			REG_ALPHA:  prdata = 32'(alpha_q);
			REG_SCALE:  prdata = 32'(scale_q);
			default:    prdata = 32'd0;
		endcase
	end

	tob_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.sts(dsts), .cmd(dcmd)
	);

	tob_dp #(.FRAME_PIXELS(FRAME_PIXELS), .MAX_SCALE(MAX_SCALE)) u_dp (
		.clk, .arst_n, .cmd(dcmd), .sts(dsts),
		.in_cmd(in.cmd), .in_first(in.first_char), .in_code(in.char_code),
		.in_x(in.pixel_x), .in_y(in.pixel_y), .in_value(in.pixel_value),
		.frame_width(width_q), .frame_height(height_q),
		.origin_x(org_x_q), .origin_y(org_y_q),
		.text_color(color_q), .text_alpha(alpha_q), .text_scale(scale_q),
		.read_data(out.read_data), .cursor_x(out.cursor_x), .cursor_y(out.cursor_y),
		.pixels_blended(out.pixels_blended)
	);
endmodule
`default_nettype wire
